>>> rtl/core/socd_pkg.sv
// Shared types and constants for the last-input-priority SOCD unit.
package socd_pkg;

  localparam int unsigned CfgSlots  = 4;
  localparam int unsigned KeyW      = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned MapW      = 4;

  localparam logic [CfgIndexW-1:0] CFG_SLOT0       = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_GROUP_MAP   = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_SLOT_ENABLE = 3'd5;

  localparam logic [CfgSlots-1:0][KeyW-1:0] SlotCodeRst = {8'd87, 8'd83, 8'd68, 8'd65};
  localparam logic [MapW-1:0] GroupMapRst   = 4'd12;
  localparam logic [MapW-1:0] SlotEnableRst = 4'd15;

  typedef struct packed {
    logic            hook_ok;
    logic            target_active;
    logic            is_injected;
    logic            is_press;
    logic [KeyW-1:0] key_code;
  } socd_evt_t;

  typedef struct packed {
    logic            kind;
    logic [KeyW-1:0] out_key;
    logic            out_press;
  } socd_res_t;

endpackage

>>> rtl/core/socd_cfg_regs.sv
// Configuration registers: slot key codes, group map and slot enables.
module socd_cfg_regs import socd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [CfgIndexW-1:0]               cfg_index_i,
  input  logic [CfgDataW-1:0]                cfg_data_i,
  output logic [((NUM_SLOTS < CfgSlots) ? NUM_SLOTS : CfgSlots)-1:0][KeyW-1:0] slot_code_o,
  output logic [MapW-1:0]                    group_map_o,
  output logic [MapW-1:0]                    slot_enable_o
);

  function automatic int unsigned ActSlotsOf(int unsigned n);
    return (n < CfgSlots) ? n : CfgSlots;
  endfunction

  localparam int unsigned ActSlots = ActSlotsOf(NUM_SLOTS);

  logic [ActSlots-1:0][KeyW-1:0] slot_code_q;
  logic [MapW-1:0]               group_map_q;
  logic [MapW-1:0]               slot_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ActSlots; i++) begin
        slot_code_q[i] <= SlotCodeRst[i];
      end
      group_map_q   <= GroupMapRst;
      slot_enable_q <= SlotEnableRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GROUP_MAP: begin
          group_map_q <= cfg_data_i[MapW-1:0];
        end
        CFG_SLOT_ENABLE: begin
          slot_enable_q <= cfg_data_i[MapW-1:0];
        end
        default: begin
          for (int i = 0; i < ActSlots; i++) begin
            if (cfg_index_i == CFG_SLOT0 + CfgIndexW'(i)) begin
              slot_code_q[i] <= cfg_data_i[KeyW-1:0];
            end
          end
        end
      endcase
    end
  end

  assign slot_code_o   = slot_code_q;
  assign group_map_o   = group_map_q;
  assign slot_enable_o = slot_enable_q;

endmodule

>>> rtl/core/socd_resolve.sv
// Slot match, group state and result generation for one key event.
module socd_resolve import socd_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 4,
  parameter int unsigned NUM_GROUPS = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  socd_evt_t                            evt_i,
  input  logic                                 fire_i,
  input  logic [((NUM_SLOTS < CfgSlots) ? NUM_SLOTS : CfgSlots)-1:0][KeyW-1:0] slot_code_i,
  input  logic [MapW-1:0]                      group_map_i,
  input  logic [MapW-1:0]                      slot_enable_i,
  output logic [1:0]                           res_cnt_o,
  output socd_res_t                            res0_o,
  output socd_res_t                            res1_o
);

  function automatic int unsigned ActSlotsOf(int unsigned n);
    return (n < CfgSlots) ? n : CfgSlots;
  endfunction

  localparam int unsigned ActSlots = ActSlotsOf(NUM_SLOTS);
  localparam int unsigned SlotW    = (ActSlots > 1) ? $clog2(ActSlots) : 1;
  localparam int unsigned RefW     = $clog2(ActSlots + 1);
  localparam int unsigned GroupW   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  logic [ActSlots-1:0]           held_q;
  logic [NUM_GROUPS-1:0][RefW-1:0] act_q;
  logic [NUM_GROUPS-1:0][RefW-1:0] prev_q;

  logic             hit;
  logic [SlotW-1:0] slot;
  logic [GroupW-1:0] grp;
  logic [RefW-1:0]  me;
  logic [RefW-1:0]  act, prev, act_n, prev_n;
  logic             held, held_n;
  logic [RefW-1:0]  act_m1, prevn_m1;

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    if (evt_i.hook_ok && evt_i.target_active && !evt_i.is_injected) begin
      for (int i = ActSlots - 1; i >= 0; i--) begin
        if (slot_enable_i[i] && slot_code_i[i] == evt_i.key_code) begin
          hit  = 1'b1;
          slot = SlotW'(i);
        end
      end
    end
  end

  assign grp  = (NUM_GROUPS > 1) ? GroupW'(group_map_i[slot]) : '0;
  assign me   = RefW'(slot) + RefW'(1);
  assign act  = act_q[grp];
  assign prev = prev_q[grp];
  assign held = held_q[slot];
  assign act_m1 = act - RefW'(1);

  always_comb begin
    res_cnt_o = 2'd0;
    res0_o    = '{kind: 1'b0, out_key: evt_i.key_code, out_press: evt_i.is_press};
    res1_o    = '{kind: 1'b1, out_key: evt_i.key_code, out_press: 1'b0};
    act_n     = act;
    prev_n    = prev;
    held_n    = held;
    prevn_m1  = '0;
    if (!hit) begin
      res_cnt_o = 2'd1;
    end else if (evt_i.is_press) begin
      if (!held) begin
        held_n    = 1'b1;
        res0_o    = '{kind: 1'b1, out_key: evt_i.key_code, out_press: 1'b1};
        res_cnt_o = 2'd1;
        act_n     = me;
        if (act != '0 && act != me) begin
          prev_n    = act;
          res1_o    = '{kind: 1'b1, out_key: slot_code_i[act_m1[SlotW-1:0]],
                        out_press: 1'b0};
          res_cnt_o = 2'd2;
        end
      end
    end else begin
      if (prev == me && !held) begin
        prev_n = '0;
      end
      if (held) begin
        held_n = 1'b0;
        res0_o = '{kind: 1'b1, out_key: evt_i.key_code, out_press: 1'b0};
        if (act == me && prev != '0) begin
          prevn_m1  = prev - RefW'(1);
          act_n     = prev;
          prev_n    = '0;
          res1_o    = '{kind: 1'b1, out_key: slot_code_i[prevn_m1[SlotW-1:0]],
                        out_press: 1'b1};
          res_cnt_o = 2'd2;
        end else begin
          prev_n    = '0;
          res_cnt_o = 2'd1;
          if (act == me) begin
            act_n = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      act_q  <= '0;
      prev_q <= '0;
    end else if (fire_i && hit) begin
      held_q[slot] <= held_n;
      act_q[grp]   <= act_n;
      prev_q[grp]  <= prev_n;
    end
  end

endmodule

>>> rtl/core/socd_last_input_priority_unit.sv
// Top level of the last-input-priority SOCD unit: input register and result buffer.
// Each key event is held in an input register, resolved combinationally against the slot
// and group state, and its zero, one or two results are written into a two-entry result
// buffer that drives the output stream. The event waits in the input register until the
// buffer is free; its first result is then registered into the buffer head. An event
// that gives two results keeps the buffer busy until both have left, because the single
// output port drains one result per cycle while m_axis_tready is high. The input register
// accepts the next event while results wait.
module socd_last_input_priority_unit import socd_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 4,
  parameter int unsigned NUM_GROUPS = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // key_code[7:0], is_press[8], is_injected[9], target_active[10], hook_ok[11]
  input  logic [15:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_key[7:0], out_press[8]
  output logic [15:0]          m_axis_tdata,
  // kind[0]
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ActSlots = (NUM_SLOTS < CfgSlots) ? NUM_SLOTS : CfgSlots;

  logic [ActSlots-1:0][KeyW-1:0] slot_code;
  logic [MapW-1:0]               group_map;
  logic [MapW-1:0]               slot_enable;

  socd_evt_t evt_q;
  logic      in_valid_q;
  logic      fire;
  logic [1:0] res_cnt;
  socd_res_t res0, res1;

  socd_res_t head_q, tail_q;
  logic      head_last_q;
  logic      head_valid_q, tail_valid_q;
  logic      buf_free;

  assign cfg_ready_o = 1'b1;

  socd_cfg_regs #(.NUM_SLOTS(NUM_SLOTS)) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .slot_code_o   (slot_code),
    .group_map_o   (group_map),
    .slot_enable_o (slot_enable)
  );

  socd_resolve #(.NUM_SLOTS(NUM_SLOTS), .NUM_GROUPS(NUM_GROUPS)) u_resolve (
    .clk_i,
    .rst_ni,
    .evt_i         (evt_q),
    .fire_i        (fire),
    .slot_code_i   (slot_code),
    .group_map_i   (group_map),
    .slot_enable_i (slot_enable),
    .res_cnt_o     (res_cnt),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  assign buf_free      = !head_valid_q || (m_axis_tready && !tail_valid_q);
  assign fire          = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      evt_q <= s_axis_tdata[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      tail_valid_q <= 1'b0;
      head_last_q  <= 1'b0;
    end else if (fire && res_cnt != 2'd0) begin
      head_valid_q <= 1'b1;
      head_last_q  <= (res_cnt == 2'd1);
      tail_valid_q <= (res_cnt == 2'd2);
    end else if (m_axis_tvalid && m_axis_tready) begin
      head_valid_q <= tail_valid_q;
      head_last_q  <= 1'b1;
      tail_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_cnt != 2'd0) begin
      head_q <= res0;
      tail_q <= res1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      head_q <= tail_q;
    end
  end

  assign m_axis_tvalid = head_valid_q;
  assign m_axis_tdata  = {7'd0, head_q.out_press, head_q.out_key};
  assign m_axis_tuser  = head_q.kind;
  assign m_axis_tlast  = head_last_q;

`ifndef NO_ASSERTIONS
  a_tail_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_valid_q |-> head_valid_q)
    else $error("second result buffered without a first");

  a_not_last_has_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_q && !head_last_q) |-> tail_valid_q)
    else $error("result not marked last but no follow-up buffered");

  a_pass_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("passed-through event not marked last");
`endif

endmodule
